### hdl/elevator_request_scheduler_defines.svh
// Assertion macros for the elevator request scheduler.
`ifndef ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH
`define ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ERS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elevator_request_scheduler assertion failed");
// Next-cycle implication, checked outside reset.
`define ERS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elevator_request_scheduler assertion failed");
`else
`define ERS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ERS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/ers_pkg.sv
// Types, codes and helpers for the elevator request scheduler.
package ers_pkg;

  localparam int unsigned FloorW = 7;

  typedef logic [FloorW-1:0] floor_t;

  typedef enum logic [1:0] {
    DirIdle = 2'd0,
    DirUp   = 2'd1,
    DirDown = 2'd2
  } dir_e;

  localparam logic CmdRequest = 1'b0;
  localparam logic CmdTick    = 1'b1;

  // Floor count clamped to 1..max_floors.
  function automatic floor_t eff_count(input floor_t cnt, input floor_t max_floors);
    floor_t res;
    if (cnt == '0) begin
      res = floor_t'(1);
    end else if (cnt > max_floors) begin
      res = max_floors;
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

### hdl/elevator_request_scheduler.sv
// Elevator request scheduler (LOOK discipline), top level.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  input    | in_valid_i / in_ready_o    | command_i, floor_i
//  result   | out_valid_o / out_ready_i  | car_floor_o, travel_dir_o, doors_open_o,
//           |                            | request_rejected_o, any_pending_o
//  config   | cfg_we_i (no wait)         | cfg_wdata_i (floor_count)
//
// One item per cycle sustained while the result side does not stall.
// An item sits in the input register, then one pass of compare/mask logic over the
// pending map updates the car state and loads the result register in the same edge.
// Reset: 16 floors, nothing pending, car at floor 1, idle.
// A stalled result holds the result register; the input register still takes an item
// while it is empty, so the input side stalls only once both registers are full.
`include "elevator_request_scheduler_defines.svh"

module elevator_request_scheduler #(
  parameter int unsigned MAX_FLOORS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [6:0] floor_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] car_floor_o,
  output logic [1:0] travel_dir_o,
  output logic       doors_open_o,
  output logic       request_rejected_o,
  output logic       any_pending_o
);

  localparam ers_pkg::floor_t MaxFloorsW = ers_pkg::floor_t'(MAX_FLOORS);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  ers_pkg::floor_t       floor_count_q;
  logic [MAX_FLOORS-1:0] pending_q, pending_d;
  ers_pkg::floor_t       position_q, position_d;
  ers_pkg::dir_e         heading_q, heading_d;

  // input register
  logic                  s1_valid_q;
  logic                  s1_cmd_q;
  ers_pkg::floor_t       s1_floor_q;

  // result register
  logic                  out_valid_q;
  ers_pkg::floor_t       res_floor_q;
  ers_pkg::dir_e         res_dir_q;
  logic                  res_doors_q, res_doors_d;
  logic                  res_rej_q, res_rej_d;
  logic                  res_any_q;

  // Handshake: the result register loads from a full input register when it is empty or being drained.
  logic adv;
  logic in_acc;
  assign adv    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || adv;

  // ---------------------------------------------------------------------------
  // Item processing
  // ---------------------------------------------------------------------------
  ers_pkg::floor_t       n_cur;
  ers_pkg::floor_t       pos_mv;
  logic [MAX_FLOORS-1:0] req_mask;
  logic [MAX_FLOORS-1:0] hit_mask;
  logic [MAX_FLOORS-1:0] above_mask;
  logic [MAX_FLOORS-1:0] below_mask;
  logic [MAX_FLOORS-1:0] pend_clr;
  logic                  hit;

  assign n_cur = ers_pkg::eff_count(floor_count_q, MaxFloorsW);

  // Tick: step one floor unless at the shaft end or idle.
  always_comb begin
    pos_mv = position_q;
    if (heading_q == ers_pkg::DirUp && position_q < n_cur) begin
      pos_mv = position_q + ers_pkg::floor_t'(1);
    end else if (heading_q == ers_pkg::DirDown && position_q > ers_pkg::floor_t'(1)) begin
      pos_mv = position_q - ers_pkg::floor_t'(1);
    end
  end

  // Per-floor decode; bit i is floor i+1.
  always_comb begin
    for (int i = 0; i < MAX_FLOORS; i++) begin
      req_mask[i] = (ers_pkg::floor_t'(i + 1) == s1_floor_q);
      hit_mask[i] = (ers_pkg::floor_t'(i + 1) == pos_mv);
    end
  end

  assign hit      = |(pending_q & hit_mask);
  assign pend_clr = pending_q & ~hit_mask;

  always_comb begin
    for (int i = 0; i < MAX_FLOORS; i++) begin
      above_mask[i] = pend_clr[i] && (ers_pkg::floor_t'(i + 1) > pos_mv);
      below_mask[i] = pend_clr[i] && (ers_pkg::floor_t'(i + 1) < pos_mv);
    end
  end

  always_comb begin
    pending_d   = pending_q;
    position_d  = position_q;
    heading_d   = heading_q;
    res_doors_d = 1'b0;
    res_rej_d   = 1'b0;
    if (s1_cmd_q == ers_pkg::CmdRequest) begin
      if (s1_floor_q == '0 || s1_floor_q > n_cur) begin
        res_rej_d = 1'b1;
      end else if (s1_floor_q == position_q) begin
        res_doors_d = 1'b1;
      end else begin
        pending_d = pending_q | req_mask;
        if (heading_q == ers_pkg::DirIdle) begin
          heading_d = (s1_floor_q > position_q) ? ers_pkg::DirUp : ers_pkg::DirDown;
        end
      end
    end else begin
      position_d  = pos_mv;
      pending_d   = pend_clr;
      res_doors_d = hit;
      // LOOK: keep going while something lies ahead, else turn around.
      if (pend_clr == '0) begin
        heading_d = ers_pkg::DirIdle;
      end else if (heading_q == ers_pkg::DirDown) begin
        heading_d = (|below_mask) ? ers_pkg::DirDown : ers_pkg::DirUp;
      end else begin
        heading_d = (|above_mask) ? ers_pkg::DirUp : ers_pkg::DirDown;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register write: drop floors past the new count, clamp the car
  // ---------------------------------------------------------------------------
  ers_pkg::floor_t       n_new;
  logic [MAX_FLOORS-1:0] keep_mask;
  logic [MAX_FLOORS-1:0] pend_cfg;

  assign n_new = ers_pkg::eff_count(cfg_wdata_i, MaxFloorsW);

  always_comb begin
    for (int i = 0; i < MAX_FLOORS; i++) begin
      keep_mask[i] = (ers_pkg::floor_t'(i) < n_new);
    end
  end

  assign pend_cfg = pending_q & keep_mask;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_count_q <= ers_pkg::floor_t'(16);
      pending_q     <= '0;
      position_q    <= ers_pkg::floor_t'(1);
      heading_q     <= ers_pkg::DirIdle;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // the user must write only while no item is in flight; the block itself does not enforce it
        floor_count_q <= cfg_wdata_i;
        pending_q     <= pend_cfg;
        if (position_q > n_new) begin
          position_q <= n_new;
        end
        if (pend_cfg == '0) begin
          heading_q <= ers_pkg::DirIdle;
        end
      end else if (adv) begin
        pending_q  <= pending_d;
        position_q <= position_d;
        heading_q  <= heading_d;
      end

      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end

      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= command_i;
      s1_floor_q <= floor_i;
    end
    if (adv) begin
      res_floor_q <= position_d;
      res_dir_q   <= heading_d;
      res_doors_q <= res_doors_d;
      res_rej_q   <= res_rej_d;
      res_any_q   <= |pending_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign car_floor_o        = res_floor_q;
  assign travel_dir_o       = 2'(res_dir_q);
  assign doors_open_o       = res_doors_q;
  assign request_rejected_o = res_rej_q;
  assign any_pending_o      = res_any_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ERS_ASSERT_IMP(a_idle_when_empty, clk_i, rst_ni, pending_q == '0, heading_q == ers_pkg::DirIdle)
  `ERS_ASSERT_IMP(a_car_in_shaft, clk_i, rst_ni, 1'b1, position_q != '0 && position_q <= n_cur)
  `ERS_ASSERT_IMP(a_doors_xor_rej, clk_i, rst_ni, out_valid_q, !(res_doors_q && res_rej_q))
  `ERS_ASSERT_NXT(a_result_follows, clk_i, rst_ni, adv, out_valid_q && res_any_q == (pending_q != '0))

endmodule
